// ----- src/ttcl_pkg.sv -----
package ttcl_pkg;

    // Trip table geometry.
    localparam int unsigned TRIP_SLOTS = 7;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned NUM_REGS   = TRIP_SLOTS + 1;
    localparam int unsigned ADDR_W     = $clog2(NUM_REGS) + 2;

    // Highest number of trips that the block honors; larger counts are clamped.
    localparam logic [IDX_W-1:0] MAX_TRIPS = 3'd7;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_TRIP_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRIP_WORD0 = 3'd1;

    // Level code meaning that no trip is in force.
    localparam logic signed [3:0] LEVEL_NONE = -4'sd1;

    function automatic logic [7:0] trip_trigger(input logic [31:0] word);
        return word[7:0];
    endfunction

    function automatic logic [7:0] trip_offset(input logic [31:0] word);
        return word[15:8];
    endfunction

    function automatic logic [15:0] trip_limit(input logic [31:0] word);
        return word[31:16];
    endfunction

endpackage

// ----- src/thermal_trip_current_limiter.sv -----
// Sequence: an accepted item runs an upward scan over up to trip_count trips, then a fetch
// of the higher trip or a downward walk, then a load of the output register, which waits
// on a stalled output; an unchanged level ends the item after the scan. Throughput: one item
// at a time, through a single shared subtract-and-compare unit, with o_stall high until done.
// Reset: synchronous, active low; clears the trip table and count, sets the active level
// to none and empties the output register.
module thermal_trip_current_limiter #(
    parameter logic [ttcl_pkg::IDX_W-1:0]   MAX_TRIPS = ttcl_pkg::MAX_TRIPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [8:0]               i_temperature,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_limit_active,
    output logic [15:0]                     o_limit_ma,
    output logic signed [3:0]               o_new_level,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttcl_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    localparam int unsigned IW = ttcl_pkg::IDX_W;

    // Configuration registers.
    logic [IW-1:0]    r_trip_count;
    logic [31:0]      r_trip_word [ttcl_pkg::TRIP_SLOTS];

    // Sequencer state.
    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic signed [3:0] r_active_level, n_active_level;
    logic signed [8:0] r_temp, n_temp;

    // Pending result.
    logic             r_res_active, n_res_active;
    logic [15:0]      r_res_ma, n_res_ma;
    logic signed [3:0] r_res_level, n_res_level;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic             r_out_active, n_out_active;
    logic [15:0]      r_out_ma, n_out_ma;
    logic signed [3:0] r_out_level, n_out_level;

    logic             cfg_write;
    logic [IW-1:0]    cfg_idx;
    logic [IW-1:0]    count_eff;
    logic [31:0]      cur_word;
    logic signed [9:0] temp_ext;
    logic signed [9:0] unit_ref;
    logic             unit_lt;
    logic             unit_gt;
    logic             scan_stop;
    logic signed [3:0] scan_level;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ttcl_pkg::ADDR_W-1:2];
    assign pready    = 1'b1;

    always_comb begin
        if (cfg_idx == ttcl_pkg::REG_TRIP_COUNT) begin
            prdata = {{(32-IW){1'b0}}, r_trip_count};
        end else begin
            prdata = r_trip_word[cfg_idx - ttcl_pkg::REG_TRIP_WORD0];
        end
    end

    assign count_eff = (r_trip_count > MAX_TRIPS) ? MAX_TRIPS : r_trip_count;

    // Shared unit: the scan compares against the trigger, the walk against
    // trigger minus offset, both at ten bits signed.
    assign cur_word = r_trip_word[r_idx];
    assign temp_ext = {r_temp[8], r_temp};
    assign unit_ref = $signed({2'b00, ttcl_pkg::trip_trigger(cur_word)})
                    - $signed((r_state == ST_WALK) ? {2'b00, ttcl_pkg::trip_offset(cur_word)}
                                                   : 10'd0);
    assign unit_lt  = temp_ext < unit_ref;
    assign unit_gt  = temp_ext > unit_ref;

    assign scan_stop  = unit_lt || (r_idx == count_eff - 3'd1);
    assign scan_level = unit_lt ? ($signed({1'b0, r_idx}) - 4'sd1) : $signed({1'b0, r_idx});

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_active_level = r_active_level;
        n_temp         = r_temp;
        n_res_active   = r_res_active;
        n_res_ma       = r_res_ma;
        n_res_level    = r_res_level;
        n_out_valid    = r_out_valid && i_stall;
        n_out_active   = r_out_active;
        n_out_ma       = r_out_ma;
        n_out_level    = r_out_level;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_temp = i_temperature;
                    n_idx  = '0;
                    // A disabled block drops the item and keeps its level.
                    if (count_eff != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_stop) begin
                    if (scan_level == r_active_level) begin
                        n_state = ST_IDLE;
                    end else if (scan_level > r_active_level) begin
                        n_idx   = scan_level[IW-1:0];
                        n_state = ST_FETCH;
                    end else begin
                        n_idx   = r_active_level[IW-1:0];
                        n_state = ST_WALK;
                    end
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ST_FETCH: begin
                n_res_active = 1'b1;
                n_res_ma     = ttcl_pkg::trip_limit(cur_word);
                n_res_level  = $signed({1'b0, r_idx});
                n_state      = ST_DONE;
            end
            ST_WALK: begin
                if (unit_gt) begin
                    n_res_active = 1'b1;
                    n_res_ma     = ttcl_pkg::trip_limit(cur_word);
                    n_res_level  = $signed({1'b0, r_idx});
                    n_state      = ST_DONE;
                end else if (r_idx == '0) begin
                    n_res_active = 1'b0;
                    n_res_ma     = '0;
                    n_res_level  = ttcl_pkg::LEVEL_NONE;
                    n_state      = ST_DONE;
                end else begin
                    n_idx = r_idx - 3'd1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid    = 1'b1;
                    n_out_active   = r_res_active;
                    n_out_ma       = r_res_ma;
                    n_out_level    = r_res_level;
                    n_active_level = r_res_level;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_active_level <= ttcl_pkg::LEVEL_NONE;
            r_out_valid    <= 1'b0;
            r_trip_count   <= '0;
            for (int k = 0; k < ttcl_pkg::TRIP_SLOTS; k++) begin
                r_trip_word[k] <= '0;
            end
        end else begin
            r_state        <= n_state;
            r_active_level <= n_active_level;
            r_out_valid    <= n_out_valid;
            if (cfg_write) begin
                if (cfg_idx == ttcl_pkg::REG_TRIP_COUNT) begin
                    r_trip_count <= pwdata[IW-1:0];
                end else begin
                    r_trip_word[cfg_idx - ttcl_pkg::REG_TRIP_WORD0] <= pwdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_temp       <= n_temp;
        r_res_active <= n_res_active;
        r_res_ma     <= n_res_ma;
        r_res_level  <= n_res_level;
        r_out_active <= n_out_active;
        r_out_ma     <= n_out_ma;
        r_out_level  <= n_out_level;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_limit_active = r_out_active;
    assign o_limit_ma     = r_out_ma;
    assign o_new_level    = r_out_level;

    // The stored level never leaves the range of trips that can exist.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active_level >= ttcl_pkg::LEVEL_NONE) && (r_active_level <= 4'sd6))
        else $error("active level out of range");

    // The downward walk only runs at or below an active trip.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ((r_active_level >= 4'sd0)
                                  && ($signed({1'b0, r_idx}) <= r_active_level)))
        else $error("walk index above active level");

    // A shown result agrees with itself: none level means no limit.
    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_limit_active == (o_new_level != ttcl_pkg::LEVEL_NONE))
                     && (o_limit_active || (o_limit_ma == 16'd0))))
        else $error("inconsistent result fields");

    // An item taken while the block is disabled leaves it idle.
    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (r_trip_count == '0)) |=> (r_state == ST_IDLE))
        else $error("disabled block started work");

    // A newly loaded result carries the level the block now holds.
    a_level_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> (o_new_level == r_active_level))
        else $error("result level differs from stored level");

endmodule
